// ----- hdl/dorq_pkg.sv -----
// Shared types and constants of the deadline ordered release queue.
`default_nettype none

package dorq_pkg;

  // Field widths of the words on both channels
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned TAG_BITS  = 16;
  localparam int unsigned PEND_BITS = 5;

  typedef enum logic {
    CMD_SCHEDULE = 1'b0,
    CMD_PROCESS  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_FULL       = 2'd1,
    ST_RELEASED   = 2'd2,
    ST_NOTHING    = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                 command;
    logic [TIME_BITS-1:0] due_time;
    logic [TAG_BITS-1:0]  payload_tag;
    logic [TIME_BITS-1:0] current_time;
  } in_word_t;

  typedef struct packed {
    status_e              status;
    logic [TAG_BITS-1:0]  released_tag;
    logic [TIME_BITS-1:0] released_time;
    logic                 last;
    logic [PEND_BITS-1:0] pending_count;
  } out_word_t;

  // One queue entry as held by a cell
  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] due;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                 insert;
    logic                 shift;
    logic [TIME_BITS-1:0] key;
    logic [TAG_BITS-1:0]  new_tag;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/deadline_ordered_release_queue.sv -----
// Top level: chain of sorted cells, sequencer and output register.
// Schedule: result word in the cycle after accept; next word accepted once the output is free.
// Process: the accept cycle enters the release state, which fills the output register; then one
//   word per cycle from the head cell while the output is not stalled; set by the single head port.
// Output register decouples the sides; a stalled output holds the sequence.
// Reset (async, active low) clears valid bits and occupancy; no clearing pass.
`default_nettype none

module deadline_ordered_release_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire dorq_pkg::in_word_t in_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output dorq_pkg::out_word_t out_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE    = 2'b01,
    S_RELEASE = 2'b10
  } state_e;

  state_e                         state_q, state_d;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [dorq_pkg::TIME_BITS-1:0] now_q;
  logic                           out_valid_q, out_valid_d;
  dorq_pkg::out_word_t            out_q, out_d;

  dorq_pkg::cell_ctl_t            ctl;
  dorq_pkg::entry_t               entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]         le;
  logic [QUEUE_DEPTH-1:0]         valid_vec;

  logic out_free, accept, full;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(QUEUE_DEPTH));

  // cell control: key is the new due time when idle, the latched now otherwise
  always_comb begin
    ctl.key     = (state_q == S_IDLE) ? in_i.due_time : now_q;
    ctl.new_tag = in_i.payload_tag;
    ctl.insert  = accept && (in_i.command == dorq_pkg::CMD_SCHEDULE) && !full;
    ctl.shift   = (state_q == S_RELEASE) && out_free && le[0];
  end

  // chain of cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dorq_pkg::entry_t prev_e, next_e;
    logic             prev_le;

    if (i == 0) begin : g_head
      assign prev_e  = '0;
      assign prev_le = 1'b1;
    end else begin : g_body
      assign prev_e  = entry[i-1];
      assign prev_le = le[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = entry[i+1];
    end

    dorq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .prev_le_i (prev_le),
      .prev_i    (prev_e),
      .next_i    (next_e),
      .entry_o   (entry[i]),
      .le_o      (le[i])
    );

    assign valid_vec[i] = entry[i].valid;
  end

  // sequencer and result word
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.command == dorq_pkg::CMD_SCHEDULE) begin
            out_valid_d          = 1'b1;
            out_d.released_tag   = '0;
            out_d.released_time  = '0;
            out_d.last           = 1'b1;
            if (full) begin
              out_d.status        = dorq_pkg::ST_FULL;
              out_d.pending_count = dorq_pkg::PEND_BITS'(count_q);
            end else begin
              count_d             = CNT_W'(count_q + 1'b1);
              out_d.status        = dorq_pkg::ST_ACCEPTED;
              out_d.pending_count = dorq_pkg::PEND_BITS'(count_d);
            end
          end else begin
            state_d = S_RELEASE;
          end
        end
      end
      S_RELEASE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (le[0]) begin
            count_d             = CNT_W'(count_q - 1'b1);
            out_d.status        = dorq_pkg::ST_RELEASED;
            out_d.released_tag  = entry[0].tag;
            out_d.released_time = entry[0].due;
            out_d.last          = !le[1];
            out_d.pending_count = dorq_pkg::PEND_BITS'(count_d);
            if (!le[1]) begin
              state_d = S_IDLE;
            end
          end else begin
            // nothing due at all
            out_d.status        = dorq_pkg::ST_NOTHING;
            out_d.released_tag  = '0;
            out_d.released_time = '0;
            out_d.last          = 1'b1;
            out_d.pending_count = dorq_pkg::PEND_BITS'(count_q);
            state_d             = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      now_q <= in_i.current_time;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  // occupancy counter tracks the valid cells
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == count_q)
    else $error("occupancy differs from valid cells");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.insert |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("insert did not add one entry");

  a_release_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.shift |=> (count_q == CNT_W'($past(count_q) - 1'b1)) && out_valid_q)
    else $error("release did not remove one entry");

  // chain stays sorted by due time
  for (genvar j = 0; j + 1 < QUEUE_DEPTH; j++) begin : g_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      entry[j+1].valid |-> (entry[j].valid && (entry[j].due <= entry[j+1].due)))
      else $error("chain out of order");
  end
`endif

endmodule

`default_nettype wire

// ----- hdl/dorq_cell.sv -----
// One cell of the sorted chain: holds an entry, inserts or shifts with its neighbors.
`default_nettype none

module dorq_cell (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire dorq_pkg::cell_ctl_t ctl_i,
  input  wire                   prev_le_i,
  input  wire dorq_pkg::entry_t prev_i,
  input  wire dorq_pkg::entry_t next_i,
  output dorq_pkg::entry_t      entry_o,
  output logic                  le_o
);

  logic                           valid_q, valid_d;
  logic [dorq_pkg::TIME_BITS-1:0] due_q, due_d;
  logic [dorq_pkg::TAG_BITS-1:0]  tag_q, tag_d;

  // entry stays ahead of the key: valid and due no later than it
  assign le_o = valid_q && (due_q <= ctl_i.key);

  // next entry: hold, pull from successor on release, or open a gap on insert
  always_comb begin
    valid_d = valid_q;
    due_d   = due_q;
    tag_d   = tag_q;
    if (ctl_i.shift) begin
      valid_d = next_i.valid;
      due_d   = next_i.due;
      tag_d   = next_i.tag;
    end else if (ctl_i.insert && !le_o) begin
      if (prev_le_i) begin
        valid_d = 1'b1;
        due_d   = ctl_i.key;
        tag_d   = ctl_i.new_tag;
      end else begin
        valid_d = prev_i.valid;
        due_d   = prev_i.due;
        tag_d   = prev_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    due_q <= due_d;
    tag_q <= tag_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.due   = due_q;
  assign entry_o.tag   = tag_q;

endmodule

`default_nettype wire
